// ===== design/m3i_pkg.sv =====
// Shared constants and types for the 3x3 fixed-point matrix inverse core.
// Used by m3i_div and mat3_inverse_core; no dependencies.
package m3i_pkg;

    localparam int NL       = 9;
    localparam int EW       = 32;
    localparam int PW       = 2 * EW;
    localparam int CFW      = PW + 1;
    localparam int TW       = 97;
    localparam int DMAG_W   = TW - 1;
    localparam int NMAG_W   = PW;
    localparam int NUM_W    = NMAG_W + EW;
    localparam int QB       = EW + 1;
    localparam int CW       = DMAG_W + QB;
    localparam int THR_W    = 31;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [0:0]      REG_THRESH  = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET  = 31'd1;
    localparam logic [EW-1:0]   ONE_Q16     = 32'h0001_0000;
    localparam logic [EW-1:0]   Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [EW-1:0]   Q_MIN       = 32'h8000_0000;
    localparam logic [NL-1:0]   DIAG_MASK   = 9'b100_010_001;

    // cofactor n[i] = e[A]*e[B] - e[C]*e[D]
    localparam int COF_A [NL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int COF_B [NL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int COF_C [NL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int COF_D [NL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic valid;
        logic sing;
    } m3i_tag_t;

endpackage

// ===== design/m3i_div.sv =====
// Nine-lane restoring divider, one quotient bit per stage, shared divisor.
// Depends on m3i_pkg; instantiated by mat3_inverse_core.
module m3i_div
    import m3i_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  m3i_tag_t                     in_tag,
    input  logic [NL-1:0][NUM_W-1:0]     in_num,
    input  logic [NL-1:0]                in_neg,
    input  logic [DMAG_W-1:0]            in_dmag,
    output m3i_tag_t                     out_tag,
    output logic [NL-1:0][EW-1:0]        out_quot,
    output logic                         out_sat
);

    m3i_tag_t                 tag_reg  [QB+1];
    logic [DMAG_W-1:0]        dmag_reg [QB+1];
    logic [NL-1:0][NUM_W-1:0] rem_reg  [QB+1];
    logic [NL-1:0][QB-1:0]    q_reg    [QB+1];
    logic [NL-1:0]            ovf_reg  [QB+1];
    logic [NL-1:0]            neg_reg  [QB+1];

    m3i_tag_t                 out_tag_reg;
    logic [NL-1:0][EW-1:0]    out_quot_reg;
    logic                     out_sat_reg;

    logic [NL-1:0][EW-1:0]    quot_next;
    logic [NL-1:0]            sat_next;
    logic [NL-1:0]            ovf_next;

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            ovf_next[l] = {{QB{1'b0}}, in_num[l]} >= {in_dmag, {QB{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= in_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg[0] <= in_dmag;
            rem_reg[0]  <= in_num;
            q_reg[0]    <= '0;
            ovf_reg[0]  <= ovf_next;
            neg_reg[0]  <= in_neg;
        end
    end

    for (genvar s = 0; s < QB; s++)
    begin : g_stage
        localparam int BIT = QB - 1 - s;

        logic [CW-1:0]            trial;
        logic [NL-1:0][NUM_W-1:0] rem_next;
        logic [NL-1:0][QB-1:0]    q_next;
        logic [NL-1:0]            ge;

        always_comb
        begin
            trial = {{QB{1'b0}}, dmag_reg[s]} << BIT;
            for (int l = 0; l < NL; l++)
            begin
                ge[l]       = {{QB{1'b0}}, rem_reg[s][l]} >= trial;
                rem_next[l] = ge[l] ? (rem_reg[s][l] - trial[NUM_W-1:0]) : rem_reg[s][l];
                q_next[l]   = q_reg[s][l];
                q_next[l][BIT] = ge[l];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[s+1] <= '0;
            end
            else if (en)
            begin
                tag_reg[s+1] <= tag_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dmag_reg[s+1] <= dmag_reg[s];
                rem_reg[s+1]  <= rem_next;
                q_reg[s+1]    <= q_next;
                ovf_reg[s+1]  <= ovf_reg[s];
                neg_reg[s+1]  <= neg_reg[s];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            if (tag_reg[QB].sing)
            begin
                sat_next[l]  = 1'b0;
                quot_next[l] = DIAG_MASK[l] ? ONE_Q16 : '0;
            end
            else if (!neg_reg[QB][l])
            begin
                sat_next[l]  = ovf_reg[QB][l] | q_reg[QB][l][QB-1] | q_reg[QB][l][EW-1];
                quot_next[l] = sat_next[l] ? Q_MAX : q_reg[QB][l][EW-1:0];
            end
            else
            begin
                sat_next[l]  = ovf_reg[QB][l] | q_reg[QB][l][QB-1]
                             | (q_reg[QB][l][EW-1] & (|q_reg[QB][l][EW-2:0]));
                quot_next[l] = sat_next[l] ? Q_MIN : (~q_reg[QB][l][EW-1:0] + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_tag_reg <= '0;
        end
        else if (en)
        begin
            out_tag_reg <= tag_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_quot_reg <= quot_next;
            out_sat_reg  <= |sat_next;
        end
    end

    assign out_tag  = out_tag_reg;
    assign out_quot = out_quot_reg;
    assign out_sat  = out_sat_reg;

endmodule

// ===== design/mat3_inverse_core.sv =====
// Top level of the 3x3 Q16.16 matrix inverse: determinant pipeline, APB threshold register.
// Depends on m3i_pkg and m3i_div.
//
//  channel | handshake                  | payload
//  --------+----------------------------+---------------------------------------
//  in      | in_valid / in_ready        | col0_row0 .. col2_row2
//  out     | out_valid / out_ready      | inv_col0_row0 .. inv_col2_row2, singular, saturated
//  cfg     | psel penable pwrite pready | paddr, pwdata, prdata (singular_threshold)
//
// One matrix per cycle while the output is not stalled; 9 determinant stages, 35 divider stages
// (one quotient bit per stage over 33 bits, plus overflow check and output register).
// Reset clears all valid bits and sets the threshold to 1.
// A stalled output freezes every stage; in_ready = !out_valid || out_ready.
module mat3_inverse_core
    import m3i_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [EW-1:0] col0_row0,
    input  logic signed [EW-1:0] col0_row1,
    input  logic signed [EW-1:0] col0_row2,
    input  logic signed [EW-1:0] col1_row0,
    input  logic signed [EW-1:0] col1_row1,
    input  logic signed [EW-1:0] col1_row2,
    input  logic signed [EW-1:0] col2_row0,
    input  logic signed [EW-1:0] col2_row1,
    input  logic signed [EW-1:0] col2_row2,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [EW-1:0] inv_col0_row0,
    output logic signed [EW-1:0] inv_col0_row1,
    output logic signed [EW-1:0] inv_col0_row2,
    output logic signed [EW-1:0] inv_col1_row0,
    output logic signed [EW-1:0] inv_col1_row1,
    output logic signed [EW-1:0] inv_col1_row2,
    output logic signed [EW-1:0] inv_col2_row0,
    output logic signed [EW-1:0] inv_col2_row1,
    output logic signed [EW-1:0] inv_col2_row2,
    output logic                singular,
    output logic                saturated
);

    logic                en;
    logic [THR_W-1:0]    thr_reg;
    logic [9:1]          v_reg;

    logic signed [EW-1:0]  e1_reg  [NL];
    logic signed [EW-1:0]  e2_reg  [NL];
    logic signed [EW-1:0]  e3_reg  [NL];
    logic signed [PW-1:0]  pab2_reg [NL];
    logic signed [PW-1:0]  pcd2_reg [NL];
    logic signed [CFW-1:0] n3_reg  [NL];
    logic signed [CFW-1:0] n4_reg  [NL];
    logic signed [CFW-1:0] n5_reg  [NL];
    logic signed [CFW-1:0] n6_reg  [NL];
    logic signed [CFW-1:0] n7_reg  [NL];
    logic signed [CFW-1:0] lo4_reg [3];
    logic signed [CFW-1:0] hi4_reg [3];
    logic signed [TW-1:0]  t5_reg  [3];
    logic signed [TW-1:0]  s6_reg;
    logic signed [TW-1:0]  t6_reg;
    logic signed [TW-1:0]  det7_reg;
    logic [DMAG_W-1:0]     dmag8_reg;
    logic                  dneg8_reg;
    logic [NMAG_W-1:0]     nabs8_reg [NL];
    logic [NL-1:0]         nneg8_reg;
    logic [DMAG_W-1:0]     dmag9_reg;
    logic                  sing9_reg;
    logic [NL-1:0][NUM_W-1:0] num9_reg;
    logic [NL-1:0]         neg9_reg;

    logic signed [EW-1:0]  e_in [NL];
    logic [TW-1:0]         dneg_next;
    logic [CFW-1:0]        nneg_next [NL];
    logic [DMAG_W:0]       rnd_next;
    logic                  sing_next;

    m3i_tag_t              div_in_tag;
    m3i_tag_t              div_out_tag;
    logic [NL-1:0][EW-1:0] quot;
    logic                  div_sat;

    assign en       = ~out_valid | out_ready;
    assign in_ready = en;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_THRESH) ? {{(DATA_W-THR_W){1'b0}}, thr_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESH))
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    assign e_in[0] = col0_row0;
    assign e_in[1] = col0_row1;
    assign e_in[2] = col0_row2;
    assign e_in[3] = col1_row0;
    assign e_in[4] = col1_row1;
    assign e_in[5] = col1_row2;
    assign e_in[6] = col2_row0;
    assign e_in[7] = col2_row1;
    assign e_in[8] = col2_row2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[8:1], in_valid};
        end
    end

    always_comb
    begin
        dneg_next = -det7_reg;
        for (int i = 0; i < NL; i++)
        begin
            nneg_next[i] = -n7_reg[i];
        end
        rnd_next  = ({1'b0, dmag8_reg} + {{(DMAG_W-31){1'b0}}, 32'h8000_0000}) >> 32;
        sing_next = (dmag8_reg == '0)
                  || (rnd_next < {{(DMAG_W+1-THR_W){1'b0}}, thr_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NL; i++)
            begin
                e1_reg[i]   <= e_in[i];
                e2_reg[i]   <= e1_reg[i];
                pab2_reg[i] <= e1_reg[COF_A[i]] * e1_reg[COF_B[i]];
                pcd2_reg[i] <= e1_reg[COF_C[i]] * e1_reg[COF_D[i]];
                e3_reg[i]   <= e2_reg[i];
                n3_reg[i]   <= {pab2_reg[i][PW-1], pab2_reg[i]}
                             - {pcd2_reg[i][PW-1], pcd2_reg[i]};
                n4_reg[i]   <= n3_reg[i];
                n5_reg[i]   <= n4_reg[i];
                n6_reg[i]   <= n5_reg[i];
                n7_reg[i]   <= n6_reg[i];
                nabs8_reg[i] <= n7_reg[i][CFW-1] ? nneg_next[i][NMAG_W-1:0]
                                                 : n7_reg[i][NMAG_W-1:0];
                nneg8_reg[i] <= n7_reg[i][CFW-1];
                num9_reg[i]  <= {nabs8_reg[i], {EW{1'b0}}};
                neg9_reg[i]  <= nneg8_reg[i] ^ dneg8_reg;
            end
            for (int j = 0; j < 3; j++)
            begin
                lo4_reg[j] <= e3_reg[3*j] * $signed({1'b0, n3_reg[j][EW-1:0]});
                hi4_reg[j] <= e3_reg[3*j] * $signed(n3_reg[j][CFW-1:EW]);
                t5_reg[j]  <= $signed({hi4_reg[j], {EW{1'b0}}})
                            + $signed({{EW{lo4_reg[j][CFW-1]}}, lo4_reg[j]});
            end
            s6_reg    <= t5_reg[0] + t5_reg[1];
            t6_reg    <= t5_reg[2];
            det7_reg  <= s6_reg + t6_reg;
            dmag8_reg <= det7_reg[TW-1] ? dneg_next[DMAG_W-1:0] : det7_reg[DMAG_W-1:0];
            dneg8_reg <= det7_reg[TW-1];
            dmag9_reg <= dmag8_reg;
            sing9_reg <= sing_next;
        end
    end

    assign div_in_tag.valid = v_reg[9];
    assign div_in_tag.sing  = sing9_reg;

    m3i_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_tag   (div_in_tag),
        .in_num   (num9_reg),
        .in_neg   (neg9_reg),
        .in_dmag  (dmag9_reg),
        .out_tag  (div_out_tag),
        .out_quot (quot),
        .out_sat  (div_sat)
    );

    assign out_valid     = div_out_tag.valid;
    assign singular      = div_out_tag.sing;
    assign saturated     = div_sat;
    assign inv_col0_row0 = quot[0];
    assign inv_col0_row1 = quot[1];
    assign inv_col0_row2 = quot[2];
    assign inv_col1_row0 = quot[3];
    assign inv_col1_row1 = quot[4];
    assign inv_col1_row2 = quot[5];
    assign inv_col2_row0 = quot[6];
    assign inv_col2_row1 = quot[7];
    assign inv_col2_row2 = quot[8];

endmodule

// ===== design/m3i_checker.sv =====
// Port-level assertions for mat3_inverse_core, bound to the top level.
// Depends on m3i_pkg.
module m3i_checker
    import m3i_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input logic [EW-1:0] inv_col0_row0,
    input logic [EW-1:0] inv_col0_row1,
    input logic          singular,
    input logic          saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inv_col0_row0) && $stable(singular))
        else $error("output word dropped or changed under stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output backpressure");

    a_sing_nosat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> !saturated)
        else $error("singular word flagged saturated");

    a_sing_ident: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> inv_col0_row0 == ONE_Q16 && inv_col0_row1 == '0)
        else $error("singular word is not identity");

endmodule

bind mat3_inverse_core m3i_checker u_m3i_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .inv_col0_row0 (inv_col0_row0),
    .inv_col0_row1 (inv_col0_row1),
    .singular      (singular),
    .saturated     (saturated)
);

// ===== dv/mat3_inverse_core_test.sv =====
// Testbench for mat3_inverse_core: random and directed 3x3 Q16.16 matrices, checked
// against an in-bench predictor of the adjugate inverse. Depends on m3i_pkg and the core.
module mat3_inverse_core_test;
    import m3i_pkg::*;

    typedef struct {
        logic signed [EW-1:0] e [NL];
    } matrix_t;

    typedef struct {
        logic [EW-1:0] v [NL];
        logic          sing;
        logic          sat;
    } inverse_t;

    class inverse_scoreboard;
        inverse_t    pending [$];
        logic [30:0] threshold = 31'd1;
        int          errors = 0;

        task report(string msg);
            $display("ERROR %0t: %s", $time, msg);
            errors++;
        endtask

        function inverse_t invert(matrix_t m);
            int ia [NL] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
            int ib [NL] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
            int ic [NL] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
            int id [NL] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
            logic signed [127:0] adj [NL];
            logic signed [127:0] det, x;
            logic [127:0] dmag, rnd, mag, q;
            longint p1, p2;
            logic neg;
            inverse_t r;
            for (int i = 0; i < NL; i++)
            begin
                p1 = longint'(m.e[ia[i]]) * longint'(m.e[ib[i]]);
                p2 = longint'(m.e[ic[i]]) * longint'(m.e[id[i]]);
                adj[i] = p1;
                x = p2;
                adj[i] = adj[i] - x;
            end
            det = 0;
            for (int k = 0; k < 3; k++)
            begin
                x = m.e[3 * k];
                det = det + x * adj[k];
            end
            dmag = det[127] ? -det : det;
            rnd = (dmag + 128'h8000_0000) >> 32;
            r.sat = 1'b0;
            r.sing = (dmag == 0) || (rnd < {97'd0, threshold});
            for (int i = 0; i < NL; i++)
            begin
                if (r.sing)
                begin
                    r.v[i] = (i % 4 == 0) ? ONE_Q16 : '0;
                    continue;
                end
                mag = adj[i][127] ? -adj[i] : adj[i];
                q = (mag << 32) / dmag;
                neg = adj[i][127] ^ det[127];
                if (!neg && q > 128'h7FFF_FFFF)
                begin
                    r.v[i] = Q_MAX;
                    r.sat = 1'b1;
                end
                else if (neg && q > 128'h8000_0000)
                begin
                    r.v[i] = Q_MIN;
                    r.sat = 1'b1;
                end
                else
                    r.v[i] = neg ? -q[31:0] : q[31:0];
            end
            return r;
        endfunction

        function void note(matrix_t m);
            pending.push_back(invert(m));
        endfunction

        task check(inverse_t got);
            inverse_t exp_r;
            if (pending.size() == 0)
            begin
                report("unexpected result word");
                return;
            end
            exp_r = pending.pop_front();
            for (int i = 0; i < NL; i++)
                if (got.v[i] !== exp_r.v[i])
                    report($sformatf("entry %0d: got %h want %h", i, got.v[i], exp_r.v[i]));
            if (got.sing !== exp_r.sing)
                report($sformatf("singular: got %b want %b", got.sing, exp_r.sing));
            if (got.sat !== exp_r.sat)
                report($sformatf("saturated: got %b want %b", got.sat, exp_r.sat));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready;
    logic out_valid, out_ready = 1'b0;
    logic signed [EW-1:0] col [NL];
    logic signed [EW-1:0] inv [NL];
    logic singular, saturated;
    inverse_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_req = 1'b0;
    int cycles = 0;

    initial
        for (int i = 0; i < NL; i++)
            col[i] = '0;

    mat3_inverse_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .col0_row0(col[0]), .col0_row1(col[1]), .col0_row2(col[2]),
        .col1_row0(col[3]), .col1_row1(col[4]), .col1_row2(col[5]),
        .col2_row0(col[6]), .col2_row1(col[7]), .col2_row2(col[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .inv_col0_row0(inv[0]), .inv_col0_row1(inv[1]), .inv_col0_row2(inv[2]),
        .inv_col1_row0(inv[3]), .inv_col1_row1(inv[4]), .inv_col1_row2(inv[5]),
        .inv_col2_row0(inv[6]), .inv_col2_row1(inv[7]), .inv_col2_row2(inv[8]),
        .singular(singular), .saturated(saturated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("mat3_inverse_core_test: FAIL");
            $finish;
        end
    end

    function int idle_draw();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    task send_matrix(matrix_t m);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < NL; i++)
            col[i] <= m.e[i];
        do @(posedge clk); while (!in_ready);
        sb.note(m);
    endtask

    task write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == '0)
            sb.threshold = data[30:0];
    endtask

    task drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function logic signed [EW-1:0] span(int unsigned lim);
        return $signed($urandom_range(0, 2 * lim)) - $signed(lim);
    endfunction

    function matrix_t random_matrix();
        matrix_t m;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < NL; i++)
        begin
            case (kind)
                5, 6: m.e[i] = $urandom();
                8: m.e[i] = span(256);
                9: m.e[i] = (i % 4 == 0) ? $urandom() : span(4096);
                default: m.e[i] = span(32'h0004_0000);
            endcase
        end
        if (kind == 7)
            for (int r = 0; r < 3; r++)
                m.e[6 + r] = m.e[r] + m.e[3 + r] + span($urandom_range(0, 3));
        return m;
    endfunction

    function matrix_t fill(logic signed [EW-1:0] off, logic signed [EW-1:0] dia);
        matrix_t m;
        for (int i = 0; i < NL; i++)
            m.e[i] = (i % 4 == 0) ? dia : off;
        return m;
    endfunction

    initial
    begin
        matrix_t m;
        logic [DATA_W-1:0] thr_set [4];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity, zero, extremes, tiny and huge diagonals, dependent columns
        send_matrix(fill(0, ONE_Q16));
        send_matrix(fill(0, 0));
        send_matrix(fill(0, 1));
        send_matrix(fill(0, 32'sh7FFF_FFFF));
        send_matrix(fill(0, 32'sh8000_0000));
        send_matrix(fill(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_matrix(fill(32'sh8000_0000, 32'sh8000_0000));
        send_matrix(fill(32'sh8000_0000, 32'sh7FFF_FFFF));
        send_matrix(fill(32'sh7FFF_FFFF, 32'sh8000_0000));
        send_matrix(fill(-1, -1));
        send_matrix(fill(0, -32'sh0002_0000));
        send_matrix(fill(0, 32'sh0000_8000));
        send_matrix(fill(0, 32'sh0000_0100));
        m = fill(0, ONE_Q16);
        m.e[3] = 32'sh0003_0000;
        m.e[7] = -32'sh0001_8000;
        send_matrix(m);
        m = fill(0, 0);
        m.e[0] = 32'sh0001_0000; m.e[4] = 32'sh0002_0000; m.e[6] = 32'sh0001_0000;
        m.e[8] = 32'sh0001_0000;
        send_matrix(m);
        drain();

        // zero threshold: exact zero determinant still singular, tiny ones invert
        write_reg(3'd0, 32'd0);
        send_matrix(fill(0, 0));
        send_matrix(fill(0, 1));
        send_matrix(fill(0, 32'sh0000_0100));
        send_matrix(fill(ONE_Q16, ONE_Q16));
        drain();
        // upper bit dropped, nonexistent register ignored
        write_reg(3'd0, 32'hFFFF_FFFF);
        write_reg(3'd4, 32'h0000_0005);
        send_matrix(fill(0, 32'sh7FFF_FFFF));
        send_matrix(fill(0, ONE_Q16));
        drain();

        thr_set = '{32'd1, 32'd0, 32'h7FFF_FFFF, 32'h0000_0400};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(3'd0, ph == 3 ? $urandom_range(1, 32'h0001_0000) : thr_set[ph]);
            for (int n = 0; n < 450; n++)
            begin
                calm = (n >= 100 && n < 160);
                if (ph == 1 && n == 200)
                    hold_req = 1'b1;
                send_matrix(random_matrix());
            end
            calm = 1'b0;
            drain();
        end

        if (sb.errors == 0)
            $display("mat3_inverse_core_test: PASS");
        else
            $display("mat3_inverse_core_test: FAIL");
        $finish;
    end

    initial
    begin
        inverse_t got;
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            stall = idle_draw();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            for (int i = 0; i < NL; i++)
                got.v[i] = inv[i];
            got.sing = singular;
            got.sat = saturated;
            sb.check(got);
        end
    end
endmodule
